### hw/rtl/pdgc_pkg.sv
// Shared types and constants for the pinch distance gripper command block.
package pdgc_pkg;

    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 32;
    localparam int unsigned CoordW    = 24;
    localparam int unsigned TimeW     = 48;
    localparam int unsigned CmdW      = 17;
    localparam int unsigned ThrW      = 25;
    // Even width so every root step takes a whole bit pair of the radicand.
    localparam int unsigned SumW      = 52;
    localparam int unsigned RootW     = 26;

    localparam logic [CfgIdxW-1:0] CFG_REQUIRE_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_LOWER_THR      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_UPPER_THR      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_EPSILON        = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MIN_INTERVAL   = 3'd4;

    localparam logic REQ_GLOVE  = 1'b0;
    localparam logic REQ_TELEOP = 1'b1;

    localparam logic [CmdW-1:0] FULL_SCALE = 17'h10000;

    typedef struct packed {
        logic                     req_type;
        logic [1:0]               side;
        logic                     tips_found;
        logic signed [CoordW-1:0] thumb_x;
        logic signed [CoordW-1:0] thumb_y;
        logic signed [CoordW-1:0] thumb_z;
        logic signed [CoordW-1:0] middle_x;
        logic signed [CoordW-1:0] middle_y;
        logic signed [CoordW-1:0] middle_z;
        logic [TimeW-1:0]         timestamp_us;
        logic                     teleop_enabled;
    } t_in_item;

    typedef struct packed {
        logic            out_side;
        logic [CmdW-1:0] command;
    } t_out_item;

    // Queue entry: a glove sample that survived classification.
    typedef struct packed {
        logic                 side;
        logic [CoordW:0]      dx;
        logic [CoordW:0]      dy;
        logic [CoordW:0]      dz;
        logic [TimeW-1:0]     ts;
    } t_job;

endpackage

### hw/rtl/pinch_distance_gripper_command_core.sv
// Top level of the pinch distance gripper command block.
//   channel | direction | handshake          | payload
//   in      | input     | i_valid / o_stall  | i_item (t_in_item)
//   out     | output    | o_valid / i_stall  | o_item (t_out_item)
//   cfg     | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
// A glove sample holds the back end from its accept to the next accept, through states
// idle, 3 square steps, 26 root steps, map, 16 divide steps, decision and output.
// The divide is skipped when the distance is outside the thresholds, the output
// state when nothing is emitted, and the output waits while a beat is stalled.
// Teleop items and dropped samples finish at the front and never enter the queue.
// Reset is synchronous, active low; the two-entry queue lets the front keep
// accepting, until it is full, while the back end works or the output beat is stalled.
module pinch_distance_gripper_command_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  pdgc_pkg::t_in_item            i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output pdgc_pkg::t_out_item           o_item,
    input  logic                          i_cfg_we,
    input  logic [pdgc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [pdgc_pkg::CfgDataW-1:0] i_cfg_data
);
    import pdgc_pkg::*;

    logic            r_req_en;
    logic [ThrW-1:0] r_lower;
    logic [ThrW-1:0] r_upper;
    logic [CmdW-1:0] r_eps;
    logic [31:0]     r_interval;

    logic jv, js, qv, qs;
    t_job fj, qj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_en   <= 1'b1;
            r_lower    <= ThrW'(30000);
            r_upper    <= ThrW'(100000);
            r_eps      <= CmdW'(655);
            r_interval <= 32'd20000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REQUIRE_ENABLE: r_req_en   <= i_cfg_data[0];
                CFG_LOWER_THR:      r_lower    <= i_cfg_data[ThrW-1:0];
                CFG_UPPER_THR:      r_upper    <= i_cfg_data[ThrW-1:0];
                CFG_EPSILON:        r_eps      <= i_cfg_data[CmdW-1:0];
                CFG_MIN_INTERVAL:   r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pdgc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .i_require_enable(r_req_en),
        .o_job_valid(jv), .i_job_stall(js), .o_job(fj)
    );

    pdgc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(jv), .o_stall(js), .i_job(fj),
        .o_valid(qv), .i_stall(qs), .o_job(qj)
    );

    pdgc_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(qv), .o_stall(qs), .i_job(qj),
        .i_lower(r_lower), .i_upper(r_upper), .i_epsilon(r_eps),
        .i_min_interval(r_interval),
        .o_valid, .i_stall, .o_item
    );
endmodule

### hw/rtl/pdgc_front.sv
// Front end: accept items, latch teleop state, drop unusable glove samples.
module pdgc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pdgc_pkg::t_in_item i_item,
    input  logic              i_require_enable,
    output logic              o_job_valid,
    input  logic              i_job_stall,
    output pdgc_pkg::t_job    o_job
);
    import pdgc_pkg::*;

    logic r_latch;
    logic accept;
    logic keep;

    assign o_stall = i_job_stall;
    assign accept  = i_valid && !i_job_stall;
    assign keep    = (i_item.req_type == REQ_GLOVE) && !(i_require_enable && !r_latch)
                     && !i_item.side[1] && i_item.tips_found;

    assign o_job_valid = i_valid && keep;
    assign o_job.side  = i_item.side[0];
    assign o_job.dx    = {i_item.thumb_x[CoordW-1], i_item.thumb_x}
                         - {i_item.middle_x[CoordW-1], i_item.middle_x};
    assign o_job.dy    = {i_item.thumb_y[CoordW-1], i_item.thumb_y}
                         - {i_item.middle_y[CoordW-1], i_item.middle_y};
    assign o_job.dz    = {i_item.thumb_z[CoordW-1], i_item.thumb_z}
                         - {i_item.middle_z[CoordW-1], i_item.middle_z};
    assign o_job.ts    = i_item.timestamp_us;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= 1'b0;
        end else if (accept && i_item.req_type == REQ_TELEOP) begin
            r_latch <= i_item.teleop_enabled;
        end
    end
endmodule

### hw/rtl/pdgc_queue.sv
// Two-entry queue between front and back end.
module pdgc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pdgc_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_stall,
    output pdgc_pkg::t_job o_job
);
    import pdgc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### hw/rtl/pdgc_back.sv
// Back end: distance, square root, threshold map, divide, emit decision.
module pdgc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  pdgc_pkg::t_job             i_job,
    input  logic [pdgc_pkg::ThrW-1:0]  i_lower,
    input  logic [pdgc_pkg::ThrW-1:0]  i_upper,
    input  logic [pdgc_pkg::CmdW-1:0]  i_epsilon,
    input  logic [31:0]                i_min_interval,
    output logic                       o_valid,
    input  logic                       i_stall,
    output pdgc_pkg::t_out_item        o_item
);
    import pdgc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_SQRT = 7'b0000100,
        S_MAP  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_DEC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [1:0]        r_k;
    logic [SumW-1:0]   r_sum;
    logic [SumW-1:0]   r_rem;
    logic [RootW-1:0]  r_root;
    logic [4:0]        r_it;
    logic [ThrW:0]     r_drem;
    logic [ThrW-1:0]   r_den;
    logic [CmdW-1:0]   r_quot;
    logic [CmdW-1:0]   r_cmd;
    logic [CmdW-1:0]   r_last [2];
    logic              r_lvalid [2];
    logic [TimeW-1:0]  r_ltime [2];
    logic              r_oval;
    t_out_item         r_out;

    logic [CoordW:0]   cur_d;
    logic [CoordW-1:0] mag;
    logic [2*CoordW-1:0] sq;
    logic [SumW-1:0]   trial;
    logic [SumW-1:0]   rem_sh;
    logic [RootW-1:0]  root_ext;
    logic [ThrW:0]     dsub;
    logic [ThrW:0]     dsh;
    logic [CmdW-1:0]   last;
    logic [CmdW-1:0]   delta;
    logic [TimeW-1:0]  elapsed;
    logic              emit;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;
    assign o_item  = r_out;

    always_comb begin
        case (r_k)
            2'd0:    cur_d = r_job.dx;
            2'd1:    cur_d = r_job.dy;
            default: cur_d = r_job.dz;
        endcase
    end
    assign mag = cur_d[CoordW] ? CoordW'(-cur_d) : cur_d[CoordW-1:0];
    assign sq  = mag * mag;

    // Restoring root, two bits of the radicand per step (26 steps).
    assign rem_sh = {r_rem[SumW-3:0], r_sum[SumW-1 -: 2]};
    assign trial  = {{(SumW-RootW-2){1'b0}}, r_root, 2'b01};
    assign root_ext = r_root;

    assign dsh  = {r_drem[ThrW-1:0], 1'b0};
    assign dsub = dsh - {1'b0, r_den};

    assign last    = r_last[r_job.side];
    assign delta   = (r_cmd >= last) ? r_cmd - last : last - r_cmd;
    assign elapsed = r_job.ts - r_ltime[r_job.side];
    assign emit    = !r_lvalid[r_job.side] || delta >= i_epsilon
                     || elapsed >= {16'd0, i_min_interval};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_k   <= 2'd0;
                r_sum <= '0;
            end
            S_SQ: begin
                r_sum <= r_sum + SumW'(sq);
                r_k   <= r_k + 2'd1;
                r_rem <= '0;
                r_root <= '0;
                r_it  <= 5'd0;
            end
            S_SQRT: begin
                r_sum <= {r_sum[SumW-3:0], 2'b00};
                r_it  <= r_it + 5'd1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {root_ext[RootW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {root_ext[RootW-2:0], 1'b0};
                end
            end
            S_MAP: begin
                // Long division of (d-lower)*65536 by (upper-lower), 16 bits.
                r_drem <= (ThrW+1)'(r_root - RootW'(i_lower));
                r_den  <= i_upper - i_lower;
                r_quot <= '0;
                r_it   <= 5'd0;
                if ({1'b0, i_lower} >= r_root) begin
                    r_cmd <= '0;
                end else if (RootW'(i_upper) <= r_root) begin
                    r_cmd <= FULL_SCALE;
                end else begin
                    r_cmd <= '0;
                end
            end
            S_DIV: begin
                r_it <= r_it + 5'd1;
                if (!dsub[ThrW]) begin
                    r_drem <= dsub;
                    r_quot <= {r_quot[CmdW-2:0], 1'b1};
                end else begin
                    r_drem <= dsh;
                    r_quot <= {r_quot[CmdW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
        if (r_state == S_DIV && r_it == 5'd15) begin
            r_cmd <= !dsub[ThrW] ? {r_quot[CmdW-2:0], 1'b1} : {r_quot[CmdW-2:0], 1'b0};
        end
        if (r_state == S_DEC && emit) begin
            r_last[r_job.side]  <= r_cmd;
            r_ltime[r_job.side] <= r_job.ts;
        end
        // Load the output beat only once the previous one has gone.
        if (r_state == S_OUT && (!r_oval || !i_stall)) begin
            r_out.out_side <= r_job.side;
            r_out.command  <= r_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oval      <= 1'b0;
            r_lvalid[0] <= 1'b0;
            r_lvalid[1] <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_oval || !i_stall)) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_SQ;
                S_SQ:   if (r_k == 2'd2) r_state <= S_SQRT;
                S_SQRT: if (r_it == 5'(RootW-1)) r_state <= S_MAP;
                S_MAP: begin
                    if ({1'b0, i_lower} >= r_root || RootW'(i_upper) <= r_root) begin
                        r_state <= S_DEC;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV:  if (r_it == 5'd15) r_state <= S_DEC;
                S_DEC: begin
                    if (emit) begin
                        r_lvalid[r_job.side] <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_oval || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
